[rtl/nlcr_pkg.sv]
// shared constants and types for the nmea line capture ring
package nlcr_pkg;

   localparam int LINE_MAX_DEFAULT   = 82;
   localparam int SLOT_COUNT_DEFAULT = 3;

   localparam int CHAR_W  = 8;
   localparam int COUNT_W = 7;
   localparam int SLOT_W  = 2;
   localparam int AGE_W   = 2;

   localparam logic [CHAR_W-1:0] LF_CHAR   = 8'h0A;
   localparam logic [CHAR_W-1:0] HIGH_CHAR = 8'h80;

   typedef enum logic {
      OP_RECEIVE = 1'b0,
      OP_READ    = 1'b1
   } op_type;

   typedef struct packed {
      logic              en;
      logic [CHAR_W-1:0] data;
   } bank_write_type;

endpackage

[rtl/nlcr_store.sv]
// line store split into even and odd byte banks, with per-entry written flags
module nlcr_store #(
   parameter int DEPTH  = 126,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  nlcr_pkg::bank_write_type      wr_even,
   input  logic [ADDR_W-1:0]             wr_even_addr,
   input  nlcr_pkg::bank_write_type      wr_odd,
   input  logic [ADDR_W-1:0]             wr_odd_addr,
   input  logic                          rd_en,
   input  logic [ADDR_W-1:0]             rd_addr,
   input  logic                          rd_odd,
   output logic [nlcr_pkg::CHAR_W-1:0]   rd_byte
);

   logic [nlcr_pkg::CHAR_W-1:0] even_mem [DEPTH];
   logic [nlcr_pkg::CHAR_W-1:0] odd_mem  [DEPTH];
   logic                        even_vld_ff [DEPTH];
   logic                        odd_vld_ff  [DEPTH];

   logic [nlcr_pkg::CHAR_W-1:0] even_data_ff;
   logic [nlcr_pkg::CHAR_W-1:0] odd_data_ff;
   logic                        even_hit_ff;
   logic                        odd_hit_ff;
   logic                        sel_odd_ff;

   // data arrays
   always_ff @(posedge clock) begin
      if (wr_even.en) begin
         even_mem[wr_even_addr] <= wr_even.data;
      end
      if (wr_odd.en) begin
         odd_mem[wr_odd_addr] <= wr_odd.data;
      end
      if (rd_en) begin
         even_data_ff <= even_mem[rd_addr];
         odd_data_ff  <= odd_mem[rd_addr];
         sel_odd_ff   <= rd_odd;
      end
   end

   // written flags, cleared at reset so unwritten bytes read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            even_vld_ff[i] <= 1'b0;
            odd_vld_ff[i]  <= 1'b0;
         end
         even_hit_ff <= 1'b0;
         odd_hit_ff  <= 1'b0;
      end else begin
         if (wr_even.en) begin
            even_vld_ff[wr_even_addr] <= 1'b1;
         end
         if (wr_odd.en) begin
            odd_vld_ff[wr_odd_addr] <= 1'b1;
         end
         if (rd_en) begin
            even_hit_ff <= even_vld_ff[rd_addr];
            odd_hit_ff  <= odd_vld_ff[rd_addr];
         end
      end
   end

   always_comb begin
      if (sel_odd_ff) begin
         rd_byte = odd_hit_ff ? odd_data_ff : '0;
      end else begin
         rd_byte = even_hit_ff ? even_data_ff : '0;
      end
   end

endmodule

[rtl/nmea_line_capture_ring.sv]
// top level: captures received text lines into a ring of line slots
// reads: a request is registered in the input stage, its result in the result stage
// throughput: one request per cycle, receive or read, while no read waits on a stalled result;
// a line feed writes both of its bytes in the same cycle through the even and odd byte banks
// reset: synchronous, clears the written flags of the whole store at once,
// the fill slot, count, write offset and reader enable; no clearing pass
module nmea_line_capture_ring #(
   parameter int LINE_MAX   = nlcr_pkg::LINE_MAX_DEFAULT,
   parameter int SLOT_COUNT = nlcr_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // rx_char[7:0], line_age[9:8], byte_index[16:10], zeros
   input  logic [0:0]  req_tuser,  // operation[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // read_data[7:0]
   output logic [0:0]  rsp_tuser,  // read_valid[0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   localparam int SLOT_BYTES = LINE_MAX + 1;
   localparam int HALF       = (SLOT_BYTES + 1) / 2;
   localparam int BANK_DEPTH = SLOT_COUNT * HALF;
   localparam int ADDR_W     = $clog2(BANK_DEPTH);
   localparam int CW         = nlcr_pkg::COUNT_W;
   localparam int SW         = nlcr_pkg::SLOT_W;

   localparam logic [ADDR_W-1:0] HALF_A      = ADDR_W'(HALF);
   localparam logic [CW-1:0]     LINE_MAX_C  = CW'(LINE_MAX);
   localparam logic [CW-1:0]     SLOT_BYTES_C = CW'(SLOT_BYTES);
   localparam logic [SW:0]       SLOT_CNT_C  = (SW + 1)'(SLOT_COUNT);
   localparam logic [SW:0]       SLOT_LAST_C = (SW + 1)'(SLOT_COUNT - 1);
   localparam logic [nlcr_pkg::AGE_W-1:0] AGE_MAX_C = nlcr_pkg::AGE_W'(SLOT_COUNT - 2);

   // input stage
   logic                          s1_valid_ff;
   nlcr_pkg::op_type              s1_op_ff;
   logic [nlcr_pkg::CHAR_W-1:0]   s1_char_ff;
   logic [nlcr_pkg::AGE_W-1:0]    s1_age_ff;
   logic [CW-1:0]                 s1_idx_ff;

   // result stage
   logic s2_valid_ff;
   logic s2_rvalid_ff;
   logic s2_show_ff;

   // line state
   logic [SW-1:0] fill_slot_ff, fill_slot_in;
   logic [CW-1:0] char_count_ff, char_count_in;
   logic [CW-1:0] write_offset_ff, write_offset_in;
   logic          reader_enable_ff;

   logic s2_free;
   logic s1_go;
   logic s1_is_read;
   logic req_take;

   logic [CW-1:0]  cnt_inc;
   logic [CW-1:0]  off_next;
   logic           put_first;
   logic           put_second;
   logic [nlcr_pkg::CHAR_W-1:0] first_data;
   logic [ADDR_W-1:0] slot_base;
   logic [ADDR_W-1:0] first_addr;
   logic [ADDR_W-1:0] second_addr;

   nlcr_pkg::bank_write_type wr_even, wr_odd;
   logic [ADDR_W-1:0]        wr_even_addr, wr_odd_addr;

   logic          age_ok;
   logic          idx_ok;
   logic [SW:0]   rd_sum;
   logic [SW-1:0] rd_slot;
   logic [ADDR_W-1:0] rd_addr;
   logic [nlcr_pkg::CHAR_W-1:0] rd_byte;

   assign s1_is_read = (s1_op_ff == nlcr_pkg::OP_READ);
   assign s2_free    = !s2_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && (!s1_is_read || s2_free);
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= nlcr_pkg::op_type'(req_tuser[0]);
         s1_char_ff <= req_tdata[7:0];
         s1_age_ff  <= req_tdata[9:8];
         s1_idx_ff  <= req_tdata[16:10];
      end
   end

   // receive path
   always_comb begin
      cnt_inc         = char_count_ff + 1'b1;
      off_next        = write_offset_ff + 1'b1;
      fill_slot_in    = fill_slot_ff;
      char_count_in   = char_count_ff;
      write_offset_in = write_offset_ff;
      put_first       = 1'b0;
      put_second      = 1'b0;
      first_data      = s1_char_ff;
      if (s1_go && !s1_is_read) begin
         priority if (cnt_inc > LINE_MAX_C) begin
            char_count_in   = '0;
            write_offset_in = '0;
         end else if (s1_char_ff == nlcr_pkg::LF_CHAR) begin
            put_first       = write_offset_ff < SLOT_BYTES_C;
            put_second      = off_next < SLOT_BYTES_C;
            char_count_in   = '0;
            write_offset_in = '0;
            if ((SW + 1)'(fill_slot_ff) >= SLOT_LAST_C) begin
               fill_slot_in = '0;
            end else begin
               fill_slot_in = fill_slot_ff + 1'b1;
            end
         end else if (s1_char_ff < nlcr_pkg::HIGH_CHAR) begin
            put_first       = write_offset_ff < SLOT_BYTES_C;
            char_count_in   = cnt_inc;
            write_offset_in = off_next;
         end else begin
            char_count_in = cnt_inc;
         end
      end
   end

   assign slot_base   = ADDR_W'(fill_slot_ff) * HALF_A;
   assign first_addr  = slot_base + ADDR_W'(write_offset_ff[CW-1:1]);
   assign second_addr = slot_base + ADDR_W'(off_next[CW-1:1]);

   // the terminator always lands in the other bank from the line feed
   always_comb begin
      if (write_offset_ff[0]) begin
         wr_odd       = '{en: put_first, data: first_data};
         wr_odd_addr  = first_addr;
         wr_even      = '{en: put_second, data: '0};
         wr_even_addr = second_addr;
      end else begin
         wr_even      = '{en: put_first, data: first_data};
         wr_even_addr = first_addr;
         wr_odd       = '{en: put_second, data: '0};
         wr_odd_addr  = second_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_slot_ff     <= '0;
         char_count_ff    <= '0;
         write_offset_ff  <= '0;
         reader_enable_ff <= 1'b0;
      end else begin
         fill_slot_ff    <= fill_slot_in;
         char_count_ff   <= char_count_in;
         write_offset_ff <= write_offset_in;
         if (csr_valid && csr_ready) begin
            reader_enable_ff <= csr_data;
         end
      end
   end

   // read path
   assign age_ok = s1_age_ff <= AGE_MAX_C;
   assign idx_ok = s1_idx_ff < SLOT_BYTES_C;

   always_comb begin
      rd_sum = (SW + 1)'(fill_slot_ff) + SLOT_LAST_C - (SW + 1)'(s1_age_ff);
      if (!age_ok) begin
         rd_slot = '0;
      end else if (rd_sum >= SLOT_CNT_C) begin
         rd_slot = SW'(rd_sum - SLOT_CNT_C);
      end else begin
         rd_slot = SW'(rd_sum);
      end
      if (idx_ok) begin
         rd_addr = ADDR_W'(rd_slot) * HALF_A + ADDR_W'(s1_idx_ff[CW-1:1]);
      end else begin
         rd_addr = '0;
      end
   end

   nlcr_store #(
      .DEPTH  (BANK_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock        (clock),
      .reset        (reset),
      .wr_even      (wr_even),
      .wr_even_addr (wr_even_addr),
      .wr_odd       (wr_odd),
      .wr_odd_addr  (wr_odd_addr),
      .rd_en        (s1_go && s1_is_read),
      .rd_addr      (rd_addr),
      .rd_odd       (s1_idx_ff[0]),
      .rd_byte      (rd_byte)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_go && s1_is_read) begin
         s2_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_is_read) begin
         s2_rvalid_ff <= reader_enable_ff && age_ok;
         s2_show_ff   <= reader_enable_ff && age_ok && idx_ok;
      end
   end

   assign rsp_tvalid   = s2_valid_ff;
   assign rsp_tdata    = s2_show_ff ? rd_byte : '0;
   assign rsp_tuser[0] = s2_rvalid_ff;

endmodule

[rtl/nlcr_checker.sv]
// port-level checks for the line capture ring, bound to the top level
module nlcr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // nothing pending after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // an invalid read carries zero data
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 8'h00)
      else $error("invalid read with non-zero data");

   // a fresh result follows an accepted read request
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready &&
                                  req_tuser[0] == nlcr_pkg::OP_READ, 2))
      else $error("result without a read request");

endmodule

bind nmea_line_capture_ring nlcr_checker u_nlcr_checker (.*);
